// ===== sv/ccc_pkg.sv =====
`default_nettype none
package ccc_pkg;
  localparam int CoordW = 32;
  localparam int RadW = 30;
  localparam int PenW = 31;
  localparam int NormW = 18;
  localparam int DsqW = 63;
endpackage
`default_nettype wire

// ===== sv/circle_circle_contact_top.sv =====
// Circle-circle contact unit.
// One input channel (in_valid / in_stall) carries a pair of circles as six
// fields; one output channel (out_valid / out_stall) carries one result
// transaction per input transaction: colliding, penetration, unit normal
// and contact point, all zero when the circles do not overlap strictly.
// The datapath is a deep pipeline: difference and squares, a 32-step
// restoring square root with one result bit per stage, two parallel
// (FRAC_BITS + 33)-step restoring dividers for the normal components, then
// the contact multiply, rounding and saturation. There are FRAC_BITS + 71
// register stages (87 at FRAC_BITS = 16). Throughput is one transaction per
// cycle while the receiver does not stall the output. The square root and
// divider stages set the length.
// A synchronous active-high rst clears every stage's valid bit; payload
// registers are not reset.
// When the receiver raises out_stall while the last stage is full, the whole
// pipeline holds (a global enable) and in_stall follows out_stall. No
// transaction is lost or repeated.
`default_nettype none
module circle_circle_contact_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [ccc_pkg::CoordW-1:0] a_center_x,
  input  wire signed [ccc_pkg::CoordW-1:0] a_center_y,
  input  wire        [ccc_pkg::RadW-1:0]   a_radius,
  input  wire signed [ccc_pkg::CoordW-1:0] b_center_x,
  input  wire signed [ccc_pkg::CoordW-1:0] b_center_y,
  input  wire        [ccc_pkg::RadW-1:0]   b_radius,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             colliding,
  output logic       [ccc_pkg::PenW-1:0]   penetration,
  output logic signed [ccc_pkg::NormW-1:0] normal_x,
  output logic signed [ccc_pkg::NormW-1:0] normal_y,
  output logic signed [ccc_pkg::CoordW-1:0] contact_x,
  output logic signed [ccc_pkg::CoordW-1:0] contact_y
);
  import ccc_pkg::*;

  // Quotient bits: q <= 2^F, so F+1 bits; numerator m<<F plus dist/2.
  localparam int QW = FRAC_BITS + 2;
  localparam int NumW = 32 + FRAC_BITS + 1;
  localparam int DivS = NumW;
  localparam int SqS = 32;
  localparam int NS = 2 + SqS + 1 + DivS + 3;

  // Pipeline advances when the output is not stalled or empty.
  logic adv;
  logic [NS-1:0] vld;
  assign adv = !(vld[NS-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Stage 0: differences, range check.
  logic signed [32:0] dx0, dy0;
  logic [31:0] mx0, my0;
  logic far0;
  logic [30:0] radii0;
  logic signed [31:0] ax0, ay0;
  logic [29:0] ra0;
  always_ff @(posedge clk) begin
    if (adv) begin
      dx0 <= 33'(b_center_x) - 33'(a_center_x);
      dy0 <= 33'(b_center_y) - 33'(a_center_y);
      radii0 <= 31'(a_radius) + 31'(b_radius);
      ax0 <= a_center_x; ay0 <= a_center_y; ra0 <= a_radius;
    end
  end
  logic [32:0] amx, amy;
  assign amx = dx0[32] ? 33'(-dx0) : 33'(dx0);
  assign amy = dy0[32] ? 33'(-dy0) : 33'(dy0);
  assign far0 = amx[32] || amy[32] || amx[31] || amy[31];
  assign mx0 = amx[31:0];
  assign my0 = amy[31:0];

  // Stage 1: squares and collision test.
  logic [DsqW-1:0] dsq1;
  logic hit1, sx1, sy1;
  logic [30:0] mx1, my1, radii1;
  logic signed [31:0] ax1, ay1;
  logic [29:0] ra1;
  always_ff @(posedge clk) begin
    if (adv) begin
      dsq1 <= 63'(62'(mx0[30:0]) * 62'(mx0[30:0])) + 63'(62'(my0[30:0]) * 62'(my0[30:0]));
      hit1 <= !far0;
      sx1 <= dx0[32]; sy1 <= dy0[32];
      mx1 <= mx0[30:0]; my1 <= my0[30:0];
      radii1 <= radii0; ax1 <= ax0; ay1 <= ay0; ra1 <= ra0;
    end
  end

  typedef struct packed {
    logic hit;
    logic sx;
    logic sy;
    logic [30:0] mx;
    logic [30:0] my;
    logic [30:0] radii;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [29:0] ra;
  } side_t;

  // Square root: restoring, one result bit per stage (MSB first, shifted in at the LSB).
  side_t sq_sd [SqS+1];
  logic [63:0] sq_rem [SqS+1];
  logic [31:0] sq_root [SqS+1];
  logic [DsqW-1:0] sq_v [SqS+1];
  assign sq_sd[0] = '{hit: hit1 && (64'(dsq1) < 64'(62'(radii1) * 62'(radii1))),
                      sx: sx1, sy: sy1, mx: mx1, my: my1, radii: radii1,
                      ax: ax1, ay: ay1, ra: ra1};
  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;
  assign sq_v[0] = dsq1;
  for (genvar i = 0; i < SqS; i++) begin : g_sq
    logic [63:0] r2, trial;
    assign r2 = {sq_rem[i][61:0], 2'(sq_v[i] >> (2 * (SqS - 1 - i)))};
    assign trial = {30'd0, sq_root[i], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sd[i+1] <= sq_sd[i];
        sq_v[i+1] <= sq_v[i];
        if (r2 >= trial) begin
          sq_rem[i+1] <= r2 - trial;
          sq_root[i+1] <= {sq_root[i][30:0], 1'b1};
        end else begin
          sq_rem[i+1] <= r2;
          sq_root[i+1] <= {sq_root[i][30:0], 1'b0};
        end
      end
    end
  end

  // Prep stage: numerators and penetration.
  side_t pd;
  logic [31:0] dist2;
  logic [NumW-1:0] nx_num, ny_num;
  logic [30:0] pen2;
  always_ff @(posedge clk) begin
    if (adv) begin
      pd <= sq_sd[SqS];
      dist2 <= sq_root[SqS];
      nx_num <= (NumW'(sq_sd[SqS].mx) << FRAC_BITS) + NumW'(sq_root[SqS] >> 1);
      ny_num <= (NumW'(sq_sd[SqS].my) << FRAC_BITS) + NumW'(sq_root[SqS] >> 1);
      pen2 <= sq_sd[SqS].radii - 31'(sq_root[SqS]);
    end
  end

  // Two restoring dividers, one quotient bit per stage.
  side_t dv_sd [DivS+1];
  logic [31:0] dv_d [DivS+1];
  logic [30:0] dv_pen [DivS+1];
  logic [NumW-1:0] xn [DivS+1], yn [DivS+1];
  logic [32:0] xr [DivS+1], yr [DivS+1];
  assign dv_sd[0] = pd; assign dv_d[0] = dist2; assign dv_pen[0] = pen2;
  assign xn[0] = nx_num; assign yn[0] = ny_num;
  assign xr[0] = '0; assign yr[0] = '0;
  for (genvar i = 0; i < DivS; i++) begin : g_div
    logic [33:0] tx, ty;
    assign tx = {xr[i], xn[i][NumW-1]};
    assign ty = {yr[i], yn[i][NumW-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sd[i+1] <= dv_sd[i]; dv_d[i+1] <= dv_d[i]; dv_pen[i+1] <= dv_pen[i];
        if (tx >= 34'(dv_d[i])) begin
          xr[i+1] <= 33'(tx - 34'(dv_d[i]));
          xn[i+1] <= {xn[i][NumW-2:0], 1'b1};
        end else begin
          xr[i+1] <= 33'(tx);
          xn[i+1] <= {xn[i][NumW-2:0], 1'b0};
        end
        if (ty >= 34'(dv_d[i])) begin
          yr[i+1] <= 33'(ty - 34'(dv_d[i]));
          yn[i+1] <= {yn[i][NumW-2:0], 1'b1};
        end else begin
          yr[i+1] <= 33'(ty);
          yn[i+1] <= {yn[i][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // Stage A: signed normal and arm.
  side_t ea;
  logic signed [QW-1:0] nxa, nya;
  logic signed [32:0] arma;
  logic [30:0] pena;
  logic [QW-2:0] qx, qy;
  logic zd;
  assign zd = dv_d[DivS] == '0;
  assign qx = zd ? '0 : xn[DivS][QW-2:0];
  assign qy = zd ? '0 : yn[DivS][QW-2:0];
  always_ff @(posedge clk) begin
    if (adv) begin
      ea <= dv_sd[DivS];
      pena <= dv_pen[DivS];
      nxa <= dv_sd[DivS].sx ? -QW'(qx) : QW'(qx);
      nya <= dv_sd[DivS].sy ? -QW'(qy) : QW'(qy);
      arma <= 33'(dv_sd[DivS].ra) - 33'(dv_pen[DivS]);
    end
  end

  // Stage B: products.
  side_t eb;
  logic signed [QW-1:0] nxb, nyb;
  logic signed [QW+32:0] px, py;
  logic [30:0] penb;
  always_ff @(posedge clk) begin
    if (adv) begin
      eb <= ea; nxb <= nxa; nyb <= nya; penb <= pena;
      px <= (QW+33)'(nxa) * (QW+33)'(arma);
      py <= (QW+33)'(nya) * (QW+33)'(arma);
    end
  end

  // Rounding half away from zero, add, saturate.
  function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                                input logic signed [QW+32:0] p);
    logic [QW+32:0] m, r;
    logic signed [QW+34:0] s;
    m = p[QW+32] ? -p : p;
    r = (m + ((QW+33)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    s = p[QW+32] ? -(QW+35)'(r) : (QW+35)'(r);
    s = s + (QW+35)'(c);
    if (s > (QW+35)'(64'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (s < -(QW+35)'(64'sh80000000)) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      colliding <= eb.hit;
      penetration <= eb.hit ? penb : '0;
      normal_x <= eb.hit ? NormW'(nxb) : '0;
      normal_y <= eb.hit ? NormW'(nyb) : '0;
      contact_x <= eb.hit ? place(eb.ax, px) : '0;
      contact_y <= eb.hit ? place(eb.ay, py) : '0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(contact_x) && $stable(penetration))
    else $error("output changed under stall");
  a_install: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !colliding |-> penetration == '0 && normal_x == '0)
    else $error("non-colliding result not zero");
endmodule
`default_nettype wire
